// File: design/rpx_pkg.sv
// ----------------------------------------------------------------------------
// rpx_pkg: shared types and constants of the range pixel back-projection unit
// Field widths, fixed-point positions, register indexes and pipeline enables.
// ----------------------------------------------------------------------------
`default_nettype none

package rpx_pkg;

    // Default width of the row and column fields.
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths.
    localparam int CODE_BITS = 16;
    localparam int STEP_BITS = 32;
    localparam int COEF_BITS = 32;
    localparam int OUT_BITS  = 32;

    // Code times step, and the depth word in Q16.16 at full width.
    localparam int PROD_BITS  = CODE_BITS + STEP_BITS;
    localparam int DEPTH_BITS = 42;
    // The depth word is multiplied in two halves; this is the unsigned low half.
    localparam int DEPTH_LO   = 21;

    // The sum of products is Q.44; round at bit 27, keep bits 59..28.
    localparam int RND_POS    = 27;
    localparam int FRAC_SHIFT = 28;
    localparam int SAT_POS    = FRAC_SHIFT + OUT_BITS - 1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic signed [COEF_BITS-1:0] H22_RESET = 32'sh1000_0000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIN_RANGE  = 3'd0,
        REG_RANGE_STEP = 3'd1,
        REG_COEF_A     = 3'd2,
        REG_COEF_B     = 3'd3,
        REG_COEF_C     = 3'd4,
        REG_COEF_D     = 3'd5,
        REG_COEF_LAST  = 3'd6
    } cfg_reg_t;

    // Load enables of the six pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } pipe_en_t;

endpackage

`default_nettype wire

// File: design/rpx_row.sv
// ----------------------------------------------------------------------------
// rpx_row: one row of the back-projection matrix
// Forms t = h0*col + h1*row + h2, multiplies it by the depth in four partial
// products, rounds the Q.44 sum to Q16.16 and saturates it to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rpx_row #(
    parameter int COORD_BITS = rpx_pkg::COORD_BITS_DEF
) (
    input  wire logic                                      aclk,
    input  wire rpx_pkg::pipe_en_t                         en,
    input  wire logic [COORD_BITS-1:0]                     pix_row,
    input  wire logic [COORD_BITS-1:0]                     pix_col,
    input  wire logic signed [rpx_pkg::COEF_BITS-1:0]      h_col,
    input  wire logic signed [rpx_pkg::COEF_BITS-1:0]      h_row,
    input  wire logic signed [rpx_pkg::COEF_BITS-1:0]      h_one,
    input  wire logic signed [rpx_pkg::DEPTH_BITS-1:0]     depth,
    output logic signed [rpx_pkg::OUT_BITS-1:0]            point
);

    localparam int PW   = rpx_pkg::COEF_BITS + COORD_BITS + 1;
    localparam int TW   = rpx_pkg::COEF_BITS + COORD_BITS + 3;
    localparam int TL   = TW / 2;
    localparam int TH   = TW - TL;
    localparam int WL   = rpx_pkg::DEPTH_LO;
    localparam int WH   = rpx_pkg::DEPTH_BITS - WL;
    localparam int LOW_W = WL + TL + 1;
    localparam int MW   = rpx_pkg::DEPTH_BITS + TH + 2;
    localparam int SW   = rpx_pkg::DEPTH_BITS + TW + 1;

    // Stage 1: coefficient times coordinate.
    logic signed [PW-1:0] hc_reg;
    logic signed [PW-1:0] hr_reg;
    // Stage 2: the row factor t.
    logic signed [TW-1:0] t_reg;
    // Stage 3: partial products of depth and t.
    logic [WL+TL-1:0]          ll_reg;
    logic signed [WL+TH:0]     lh_reg;
    logic signed [WH+TL:0]     hl_reg;
    logic signed [WH+TH-1:0]   hh_reg;
    // Stage 4: middle terms merged, rounding constant folded into the low term.
    logic [LOW_W-1:0]          low_reg;
    logic signed [MW-1:0]      mid_reg;
    logic signed [WH+TH-1:0]   hh2_reg;
    // Stage 5: full sum.
    logic signed [SW-1:0]      s_reg;
    // Stage 6: saturated result.
    logic signed [rpx_pkg::OUT_BITS-1:0] point_reg;

    logic [WL-1:0]            w_lo;
    logic signed [WH-1:0]     w_hi;
    logic [TL-1:0]            t_lo;
    logic signed [TH-1:0]     t_hi;
    logic signed [SW-1:0]     term_hi;
    logic signed [SW-1:0]     term_mid;
    logic signed [SW-1:0]     term_lo;
    logic signed [SW-1:0]     s_next;
    logic [SW-1-rpx_pkg::SAT_POS:0]      s_top;
    logic signed [rpx_pkg::OUT_BITS-1:0] point_next;

    assign w_lo = depth[WL-1:0];
    assign w_hi = depth[rpx_pkg::DEPTH_BITS-1:WL];
    assign t_lo = t_reg[TL-1:0];
    assign t_hi = t_reg[TW-1:TL];

    always_comb begin
        term_hi  = SW'(hh2_reg) <<< (WL + TL);
        term_mid = SW'(mid_reg) <<< WL;
        term_lo  = SW'(low_reg);
        s_next   = term_hi + term_mid + term_lo;
    end

    // The result fits when every bit above the kept field equals the sign.
    always_comb begin
        s_top = s_reg[SW-1:rpx_pkg::SAT_POS];
        if (!s_reg[SW-1] && (|s_top)) begin
            point_next = {1'b0, {(rpx_pkg::OUT_BITS-1){1'b1}}};
        end else if (s_reg[SW-1] && !(&s_top)) begin
            point_next = {1'b1, {(rpx_pkg::OUT_BITS-1){1'b0}}};
        end else begin
            point_next = s_reg[rpx_pkg::SAT_POS:rpx_pkg::FRAC_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            hc_reg <= h_col * $signed({1'b0, pix_col});
            hr_reg <= h_row * $signed({1'b0, pix_row});
        end
        if (en.s2) begin
            t_reg <= TW'(hc_reg) + TW'(hr_reg) + TW'(h_one);
        end
        if (en.s3) begin
            ll_reg <= w_lo * t_lo;
            lh_reg <= $signed({1'b0, w_lo}) * t_hi;
            hl_reg <= w_hi * $signed({1'b0, t_lo});
            hh_reg <= w_hi * t_hi;
        end
        if (en.s4) begin
            low_reg <= LOW_W'(ll_reg) + (LOW_W'(1) << rpx_pkg::RND_POS);
            // w_lo*t_hi weighs 2^TL and w_hi*t_lo weighs 2^WL, so the first
            // is lifted by the difference before both share the 2^WL shift.
            mid_reg <= (MW'(lh_reg) <<< (TL - WL)) + MW'(hl_reg);
            hh2_reg <= hh_reg;
        end
        if (en.s5) begin
            s_reg <= s_next;
        end
        if (en.s6) begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

`default_nettype wire

// File: design/range_pixel_to_xyz_unit.sv
// ----------------------------------------------------------------------------
// range_pixel_to_xyz_unit: back-projects range-coded depth pixels to points
// An accepted pixel passes the six-stage multiply pipeline to its point on the
// result channel. Throughput: one pixel per cycle while the result side is ready.
// Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

// Each request on the input channel carries one pixel of a 16-bit range image
// with its row and column. A pixel with a zero code, or one in the header row
// (row 0), is dropped at the first stage and produces no request on the result
// channel. Every other pixel gives one point (x, y, z) in signed Q16.16.
//
// Datapath:
//   stage 1  code * range_step, and per matrix row h0*col and h1*row
//   stage 2  depth w = round(code*step + min_range*256) to Q16.16, and
//            per matrix row t = h0*col + h1*row + h2
//   stage 3  per row, four partial products of w and t
//   stage 4  middle partials merged, rounding constant added
//   stage 5  full Q.44 sum w*t
//   stage 6  saturation to 32 bits, output register
// Since sum(h_i * vec_i) = w * (h0*col + h1*row + h2) exactly, the per-row
// factor t is formed first and multiplied by the depth only once.
//
// Every stage has a valid bit and loads whenever it is empty or its successor
// loads, so bubbles are squeezed out and a stalled result does not block the
// input side while earlier stages still have room.
//
// Configuration is written through a plain write port and is expected to be
// changed only while no pixel is in flight.

module range_pixel_to_xyz_unit #(
    parameter int COORD_BITS = rpx_pkg::COORD_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    // Configuration write port.
    input  wire logic                                  cfg_we,
    input  wire logic [rpx_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [rpx_pkg::CFG_DATA_BITS-1:0]     cfg_data,

    // Pixel input channel.
    input  wire logic s_tvalid,
    output logic      s_tready,
    // pixel_row, pixel_col, range_code from the lowest bit up, zero filled.
    input  wire logic [((2*COORD_BITS+rpx_pkg::CODE_BITS+7)/8)*8-1:0] s_tdata,

    // Point output channel.
    output logic      m_tvalid,
    input  wire logic m_tready,
    // point_x, point_y, point_z from the lowest bit up.
    output logic [3*rpx_pkg::OUT_BITS-1:0] m_tdata
);

    localparam int NUM_STAGES = 6;
    localparam int D_BITS     = rpx_pkg::DEPTH_BITS + 8;

    // Configuration registers.
    logic signed [rpx_pkg::COEF_BITS-1:0] min_range_reg;
    logic [rpx_pkg::STEP_BITS-1:0]        range_step_reg;
    logic signed [rpx_pkg::COEF_BITS-1:0] h_reg [9];

    // Pipeline control.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    rpx_pkg::pipe_en_t     en;

    // Depth path.
    logic [rpx_pkg::PROD_BITS-1:0]         prod_reg;
    logic signed [rpx_pkg::DEPTH_BITS-1:0] depth_reg;
    logic signed [39:0]                    mr_ofs;
    logic signed [D_BITS-1:0]              d_sum;

    // Input fields.
    logic [COORD_BITS-1:0]         pix_row;
    logic [COORD_BITS-1:0]         pix_col;
    logic [rpx_pkg::CODE_BITS-1:0] range_code;
    logic                          keep;

    logic signed [rpx_pkg::OUT_BITS-1:0] point [3];

    assign pix_row    = s_tdata[COORD_BITS-1:0];
    assign pix_col    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign range_code = s_tdata[2*COORD_BITS+rpx_pkg::CODE_BITS-1:2*COORD_BITS];

    // Pixels without a measurement and header-row pixels enter as bubbles.
    assign keep = (range_code != '0) && (pix_row != '0);

    // Configuration writes. Unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg  <= '0;
            range_step_reg <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= '0;
            end
            h_reg[8] <= rpx_pkg::H22_RESET;
        end else if (cfg_we) begin
            unique case (rpx_pkg::cfg_reg_t'(cfg_index))
                rpx_pkg::REG_MIN_RANGE: begin
                    min_range_reg <= cfg_data[31:0];
                end
                rpx_pkg::REG_RANGE_STEP: begin
                    range_step_reg <= cfg_data[31:0];
                end
                rpx_pkg::REG_COEF_A: begin
                    h_reg[0] <= cfg_data[63:32];
                    h_reg[1] <= cfg_data[31:0];
                end
                rpx_pkg::REG_COEF_B: begin
                    h_reg[2] <= cfg_data[63:32];
                    h_reg[3] <= cfg_data[31:0];
                end
                rpx_pkg::REG_COEF_C: begin
                    h_reg[4] <= cfg_data[63:32];
                    h_reg[5] <= cfg_data[31:0];
                end
                rpx_pkg::REG_COEF_D: begin
                    h_reg[6] <= cfg_data[63:32];
                    h_reg[7] <= cfg_data[31:0];
                end
                rpx_pkg::REG_COEF_LAST: begin
                    h_reg[8] <= cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or when the next stage takes its item.
    always_comb begin
        en.s6 = !vld_reg[5] || m_tready;
        en.s5 = !vld_reg[4] || en.s6;
        en.s4 = !vld_reg[3] || en.s5;
        en.s3 = !vld_reg[2] || en.s4;
        en.s2 = !vld_reg[1] || en.s3;
        en.s1 = !vld_reg[0] || en.s2;
    end

    assign s_tready = en.s1;

    always_comb begin
        vld_next[0] = en.s1 ? (s_tvalid && keep) : vld_reg[0];
        vld_next[1] = en.s2 ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en.s3 ? vld_reg[1] : vld_reg[2];
        vld_next[3] = en.s4 ? vld_reg[2] : vld_reg[3];
        vld_next[4] = en.s5 ? vld_reg[3] : vld_reg[4];
        vld_next[5] = en.s6 ? vld_reg[4] : vld_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // min_range*256 + 128 is the offset and the rounding constant in one word,
    // so the depth needs a single add before the shift by eight.
    assign mr_ofs = {min_range_reg, 8'h80};
    assign d_sum  = D_BITS'($signed({2'b00, prod_reg})) + D_BITS'(mr_ofs);

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod_reg <= range_code * range_step_reg;
        end
        if (en.s2) begin
            depth_reg <= d_sum[D_BITS-1:8];
        end
    end

    // One unit per matrix row: x, y and z.
    for (genvar r = 0; r < 3; r++) begin : g_row
        rpx_row #(
            .COORD_BITS(COORD_BITS)
        ) u_row (
            .aclk    (aclk),
            .en      (en),
            .pix_row (pix_row),
            .pix_col (pix_col),
            .h_col   (h_reg[3*r]),
            .h_row   (h_reg[3*r+1]),
            .h_one   (h_reg[3*r+2]),
            .depth   (depth_reg),
            .point   (point[r])
        );
    end

    assign m_tvalid = vld_reg[5];
    assign m_tdata  = {point[2], point[1], point[0]};

endmodule

`default_nettype wire

// File: tb/sv/range_pixel_to_xyz_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_pixel_to_xyz_unit_test: self-checking bench of the back-projection unit
// Pixels are streamed into the unit under random source gaps and sink stalls.
// Every accepted pixel is projected by an independent fixed-point predictor,
// and each point leaving the unit is compared against the oldest prediction.
// ----------------------------------------------------------------------------

module range_pixel_to_xyz_unit_test;

    // Index with no register behind it; the unit must ignore writes to it.
    localparam logic [rpx_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    // Six pipeline stages; settle a little longer than that before any
    // register write, since dropped pixels leave no trace on the result side.
    localparam int PIPE_LATENCY = 6;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;

    localparam int PIXEL_BITS = 40;
    localparam int POINT_BITS = 3 * rpx_pkg::OUT_BITS;

    localparam logic signed [127:0] HALF_LSB = 128'sd134217728;  // 2^27
    localparam logic signed [127:0] OUT_MAX  = 128'sd2147483647;
    localparam logic signed [127:0] OUT_MIN  = -128'sd2147483648;

    logic aclk;
    logic aresetn;

    logic                               cfg_we;
    logic [rpx_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [rpx_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    logic                  s_tvalid;
    logic                  s_tready;
    // pixel_row [11:0], pixel_col [23:12], range_code [39:24].
    logic [PIXEL_BITS-1:0] s_tdata;

    logic                  m_tvalid;
    logic                  m_tready;
    // point_x [31:0], point_y [63:32], point_z [95:64].
    logic [POINT_BITS-1:0] m_tdata;

    // Shadow copy of the unit's registers, kept in step with every write.
    logic signed [31:0] min_range_q;
    logic        [31:0] range_step_q;
    logic signed [31:0] coef_q [9];

    // Values that a test wants loaded by the next call to load_setup.
    logic signed [31:0] setup_min;
    logic        [31:0] setup_step;
    logic signed [31:0] setup_coef [9];

    // Points predicted for accepted pixels, oldest first.
    logic [POINT_BITS-1:0] points_due [$];

    int  mismatch_count;
    bit  src_idle_on;
    bit  sink_stall_on;

    range_pixel_to_xyz_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Predictor. The depth is formed exactly in Q.24, rounded half up to
    // Q16.16 without saturation, and the three matrix rows are summed exactly
    // in Q.44 before rounding half up and clamping to 32 bits. A 128-bit
    // signed accumulator holds every intermediate without loss.
    // ------------------------------------------------------------------------
    function automatic logic [POINT_BITS-1:0] project_pixel(input logic [11:0] row,
                                                            input logic [11:0] col,
                                                            input logic [15:0] code);
        logic signed [127:0] depth, step_w, offset, w, col_w, row_w;
        logic signed [127:0] h0, h1, h2, acc, q;
        logic [POINT_BITS-1:0] point;
        depth  = code;
        step_w = range_step_q;
        offset = min_range_q;
        depth  = depth * step_w + (offset <<< 8);
        w      = (depth + 128) >>> 8;
        col_w  = col;
        row_w  = row;
        col_w  = col_w * w;
        row_w  = row_w * w;
        for (int k = 0; k < 3; k++) begin
            h0  = coef_q[3*k];
            h1  = coef_q[3*k+1];
            h2  = coef_q[3*k+2];
            acc = h0 * col_w + h1 * row_w + h2 * w + HALF_LSB;
            q   = acc >>> 28;
            if (q > OUT_MAX) begin
                point[32*k +: 32] = 32'h7FFF_FFFF;
            end else if (q < OUT_MIN) begin
                point[32*k +: 32] = 32'h8000_0000;
            end else begin
                point[32*k +: 32] = q[31:0];
            end
        end
        return point;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard. Results are checked before new predictions are queued; a
    // pixel accepted at this edge cannot have its point out at the same edge.
    // Both sides are sampled at the rising edge, before the unit's own
    // registers update, so no race exists with the design.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [POINT_BITS-1:0] want;
        string field_name [3];
        field_name = '{"point_x", "point_y", "point_z"};
        if (aresetn && m_tvalid && m_tready) begin
            if (points_due.size() == 0) begin
                $display("%0t: point with no pixel pending: actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = points_due.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (m_tdata[32*k +: 32] !== want[32*k +: 32]) begin
                        $display("%0t: %s mismatch: expected %h actual %h", $time,
                                 field_name[k], want[32*k +: 32], m_tdata[32*k +: 32]);
                        mismatch_count++;
                    end
                end
            end
        end
        // Header-row pixels and empty codes are accepted but yield nothing.
        if (aresetn && s_tvalid && s_tready) begin
            if (s_tdata[11:0] != 12'd0 && s_tdata[39:24] != 16'd0) begin
                points_due.insert(points_due.size(),
                                  project_pixel(s_tdata[11:0], s_tdata[23:12],
                                                s_tdata[39:24]));
            end
        end
    end

    // Gap lengths: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result-side back-pressure. m_tready changes only at falling edges, and a stall
    // never ends at the falling edge where it began, so the two writes never share a step.
    initial begin : sink_stall
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stall_on && $urandom_range(0, 99) < 20) begin
                stall = $urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(8, 40);
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Offers one pixel request and returns once it has been taken. Valid stays
    // high between back-to-back requests and only drops for a source gap.
    task automatic send_pixel(input logic [11:0] row, input logic [11:0] col,
                              input logic [15:0] code);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {code, col, row};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops the source and waits until every predicted point has come out and
    // the pipeline has had time to flush anything that was dropped.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (points_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; the shadow registers follow the same decode.
    task automatic cfg_write(input logic [rpx_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [rpx_pkg::CFG_DATA_BITS-1:0] value);
        int k;
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index) inside
            rpx_pkg::REG_MIN_RANGE:  min_range_q = value[31:0];
            rpx_pkg::REG_RANGE_STEP: range_step_q = value[31:0];
            rpx_pkg::REG_COEF_A, rpx_pkg::REG_COEF_B,
            rpx_pkg::REG_COEF_C, rpx_pkg::REG_COEF_D: begin
                k = 2 * (int'(index) - int'(rpx_pkg::REG_COEF_A));
                coef_q[k]   = value[63:32];
                coef_q[k+1] = value[31:0];
            end
            rpx_pkg::REG_COEF_LAST:  coef_q[8] = value[31:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Loads the whole setup. The upper half of each 32-bit register write
    // carries random filler that the unit must not use.
    task automatic load_setup();
        drain_pipeline();
        cfg_write(rpx_pkg::REG_MIN_RANGE,  {32'($urandom), setup_min});
        cfg_write(rpx_pkg::REG_RANGE_STEP, {32'($urandom), setup_step});
        cfg_write(rpx_pkg::REG_COEF_A,     {setup_coef[0], setup_coef[1]});
        cfg_write(rpx_pkg::REG_COEF_B,     {setup_coef[2], setup_coef[3]});
        cfg_write(rpx_pkg::REG_COEF_C,     {setup_coef[4], setup_coef[5]});
        cfg_write(rpx_pkg::REG_COEF_D,     {setup_coef[6], setup_coef[7]});
        cfg_write(rpx_pkg::REG_COEF_LAST,  {32'($urandom), setup_coef[8]});
    endtask

    // A random signed word shifted down, so that magnitudes spread widely.
    function automatic logic signed [31:0] rand_scaled(input int lo, input int hi);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(lo, hi);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Straight after reset the depth step is zero, so every point is zero.
    task automatic test_reset_state();
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        send_pixel(12'd1, 12'd1, 16'd1);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF);
        send_pixel(12'd7, 12'd300, 16'h8000);
    endtask

    // Header-row pixels and pixels without a measurement are swallowed,
    // including back to back with a good pixel between them.
    task automatic test_dropped_pixels();
        setup_min  = 32'sh0001_0000;
        setup_step = 32'h0100_0000;
        for (int i = 0; i < 9; i++) setup_coef[i] = (i % 4 == 0) ? 32'sh1000_0000 : 32'sh0;
        load_setup();
        src_idle_on = 1'b0;
        send_pixel(12'd0, 12'd10, 16'd5);
        send_pixel(12'd3, 12'd10, 16'd0);
        send_pixel(12'd3, 12'd10, 16'd5);
        send_pixel(12'd0, 12'd4095, 16'hFFFF);
    endtask

    // Field extremes with a unit matrix, then the rounding edge: a depth of
    // exactly half an LSB rounds up, minus half an LSB rounds up to zero.
    task automatic test_field_extremes();
        src_idle_on = 1'b1;
        send_pixel(12'd1, 12'd0, 16'd1);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF);
        send_pixel(12'd1, 12'd4095, 16'd1);
        send_pixel(12'd4095, 12'd0, 16'hFFFF);
        setup_min  = -32'sd1;
        setup_step = 32'd128;
        load_setup();
        send_pixel(12'd1, 12'd1, 16'd1);
        send_pixel(12'd1, 12'd1, 16'd3);
    endtask

    // A write to an unmapped index must leave every register unchanged.
    task automatic test_unused_register();
        drain_pipeline();
        cfg_write(REG_UNUSED, {32'($urandom), 32'($urandom)});
        send_pixel(12'd2, 12'd9, 16'd1234);
        send_pixel(12'd4000, 12'd17, 16'hFFFE);
    endtask

    // Register extremes: most negative, most positive and mixed signs. These
    // drive the outputs into both saturation rails.
    task automatic test_register_extremes();
        for (int s = 0; s < 3; s++) begin
            setup_min  = (s == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            setup_step = (s == 0) ? 32'h0 : 32'hFFFF_FFFF;
            for (int i = 0; i < 9; i++) begin
                if (s == 0) setup_coef[i] = 32'sh7FFF_FFFF;
                else if (s == 1) setup_coef[i] = 32'sh8000_0000;
                else setup_coef[i] = (i % 2 == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            load_setup();
            send_pixel(12'd1, 12'd0, 16'd1);
            send_pixel(12'd4095, 12'd4095, 16'hFFFF);
            send_pixel(12'd2048, 12'd2047, 16'h7FFF);
        end
    endtask

    // Random traffic in several phases, each under a fresh setup. Even phases
    // use moderate magnitudes so most points stay inside the output range;
    // odd phases use raw random registers. Idling varies by phase, with one
    // phase at full rate on both sides.
    task automatic test_random_traffic();
        logic [11:0] row, col;
        logic [15:0] code;
        int r, points;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase % 2 == 0) begin
                setup_min  = rand_scaled(4, 24);
                setup_step = 32'($urandom) >> $urandom_range(4, 20);
                for (int i = 0; i < 9; i++) setup_coef[i] = rand_scaled(2, 20);
            end else begin
                setup_min  = $urandom;
                setup_step = $urandom;
                for (int i = 0; i < 9; i++) setup_coef[i] = $urandom;
            end
            load_setup();
            src_idle_on   = (phase != 0) && (phase != 3);
            sink_stall_on = (phase != 0) && (phase != 4);
            points = 0;
            while (points < 270) begin
                r = $urandom_range(0, 99);
                row = (r < 5) ? 12'd0 : (r < 10) ? 12'd4095 : 12'($urandom_range(1, 4095));
                r = $urandom_range(0, 99);
                col = (r < 8) ? 12'd0 : (r < 16) ? 12'd4095 : 12'($urandom);
                r = $urandom_range(0, 99);
                code = (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF : (r < 15) ? 16'd1 : 16'($urandom);
                send_pixel(row, col, code);
                if (row != 12'd0 && code != 16'd0) points++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        aresetn        = 1'b0;
        src_idle_on    = 1'b0;
        sink_stall_on  = 1'b0;
        mismatch_count = 0;
        min_range_q    = 32'sd0;
        range_step_q   = 32'd0;
        for (int i = 0; i < 9; i++) coef_q[i] = 32'sd0;
        coef_q[8]      = rpx_pkg::H22_RESET;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_dropped_pixels();
        test_field_extremes();
        test_unused_register();
        test_register_extremes();
        test_random_traffic();

        drain_pipeline();
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with every gap and stall long.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
